[hdl/tts_pkg.sv]
package tts_pkg;

  // screen geometry
  localparam int unsigned COLUMNS = 40;
  localparam int unsigned ROWS    = 24;
  localparam int unsigned CELLS   = ROWS * COLUMNS;
  localparam int unsigned BOTTOM  = (ROWS - 1) * COLUMNS;
  localparam int unsigned ADDR_W  = $clog2(CELLS);
  localparam int unsigned CNT_W   = $clog2(CELLS + 1);

  // blink defaults
  localparam int unsigned BLINK_ON_DEFAULT  = 20;
  localparam int unsigned BLINK_OFF_DEFAULT = 10;

  // field widths
  localparam int unsigned COL_W  = 6;
  localparam int unsigned ROW_W  = 5;
  localparam int unsigned CHAR_W = 7;

  // character codes
  localparam logic [7:0]        CODE_CR     = 8'h0d;
  localparam logic [7:0]        CODE_FIRST  = 8'h20;
  localparam logic [20:0]       KEY_CTRL_L  = 21'h00000c;
  localparam logic [20:0]       KEY_DEL     = 21'h00007f;
  localparam logic [20:0]       KEY_LIMIT   = 21'h000080;
  localparam logic [CHAR_W-1:0] CHAR_SPACE  = 7'h20;
  localparam logic [CHAR_W-1:0] CHAR_AT     = 7'h40;
  localparam logic [CHAR_W-1:0] CHAR_UNDER  = 7'h5f;

  typedef logic [CHAR_W-1:0] cell_t;

  // item kinds
  typedef enum logic [2:0] {
    KIND_PRINT = 3'd0,
    KIND_CLEAR = 3'd1,
    KIND_KEY   = 3'd2,
    KIND_TICK  = 3'd3,
    KIND_READ  = 3'd4
  } kind_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [7:0]       char_code;
    logic [20:0]      key_code;
    logic [ROW_W-1:0] read_row;
    logic [COL_W-1:0] read_col;
  } in_item_t;

  typedef struct packed {
    cell_t            cell_char;
    logic [COL_W-1:0] cursor_col;
    logic [ROW_W-1:0] cursor_row;
    logic             cursor_visible;
    logic             scrolled;
    logic             key_valid;
    logic [6:0]       key_out;
  } out_item_t;

  // cell store ports
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    cell_t             data;
  } ram_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } ram_rd_t;

endpackage

[hdl/tts_cell_ram.sv]
module tts_cell_ram (
  input  logic             clk,
  input  tts_pkg::ram_wr_t wr,
  input  tts_pkg::ram_rd_t rd,
  output tts_pkg::cell_t   rd_data
);
  import tts_pkg::*;

  cell_t mem_r [CELLS];
  cell_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_r <= mem_r[rd.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/text_terminal_screen_writer.sv]
// Text screen of 40 x 24 cells driven by a stream of items.
// Input channel in_valid/in_ready/in_data carries one item (print, clear,
// key, blink tick or cell read); every item gives exactly one result on
// out_valid/out_ready/out_data, in order. cfg_wr_en/cfg_wr_data write the
// ctrl-L clear enable at any clock edge, without handshake.
// Path from input transfer to result in the output register:
//   print, key, tick and unused kinds, and reads not from the store: ST_PUSH
//   cell read from the store: ST_READ for its registered read, then ST_PUSH
//   clear, ctrl-L clear, or print that scrolls: ST_SWEEP over the cell store,
//   one cell written per cycle, then ST_PUSH.
// One item is processed at a time; the next input transfer comes in the cycle
// after the result is loaded.
// After reset a clearing pass writes spaces to all 960 cells with in_ready low;
// cursor, blink state and clear enable reset to zero.
// The output register parts the two sides: a waiting result does not stop
// the next input transfer, but the following result waits until out_ready
// drains the register, and a stalled result holds steady.
module text_terminal_screen_writer #(
  parameter int unsigned BLINK_ON_TICKS  = tts_pkg::BLINK_ON_DEFAULT,
  parameter int unsigned BLINK_OFF_TICKS = tts_pkg::BLINK_OFF_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tts_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tts_pkg::out_item_t out_data,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data
);
  import tts_pkg::*;

  localparam int unsigned BLINK_MAX =
    (BLINK_ON_TICKS > BLINK_OFF_TICKS) ? BLINK_ON_TICKS : BLINK_OFF_TICKS;
  localparam int unsigned BLINK_W = $clog2(BLINK_MAX + 1);

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_READ,
    ST_PUSH
  } state_t;

  state_t               state_r, state_nxt;
  logic [COL_W-1:0]     cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]     cur_row_r, cur_row_nxt;
  logic [BLINK_W-1:0]   blink_cnt_r, blink_cnt_nxt;
  logic                 blink_phase_r, blink_phase_nxt;
  logic                 clr_cfg_r, clr_cfg_nxt;
  logic [CNT_W-1:0]     sweep_cnt_r, sweep_cnt_nxt;
  logic [ADDR_W-1:0]    sweep_wa_r, sweep_wa_nxt;
  logic                 sweep_wv_r, sweep_wv_nxt;
  logic                 sweep_scroll_r, sweep_scroll_nxt;
  logic                 res_pend_r, res_pend_nxt;
  out_item_t            res_r, res_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;

  ram_wr_t              ram_wr;
  ram_rd_t              ram_rd;
  cell_t                ram_rd_data;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(row * COLUMNS);
    return base + ADDR_W'(col);
  endfunction

  tts_cell_ram u_cell_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd      (ram_rd),
    .rd_data (ram_rd_data)
  );

  // next-state logic
  always_comb begin
    logic             adv;
    logic             start_clear;
    logic [COL_W-1:0] col_v;
    logic [ROW_W-1:0] row_v;

    adv              = 1'b0;
    start_clear      = 1'b0;
    col_v            = cur_col_r;
    row_v            = cur_row_r;
    state_nxt        = state_r;
    cur_col_nxt      = cur_col_r;
    cur_row_nxt      = cur_row_r;
    blink_cnt_nxt    = blink_cnt_r;
    blink_phase_nxt  = blink_phase_r;
    clr_cfg_nxt      = clr_cfg_r;
    sweep_cnt_nxt    = sweep_cnt_r;
    sweep_wa_nxt     = sweep_wa_r;
    sweep_wv_nxt     = sweep_wv_r;
    sweep_scroll_nxt = sweep_scroll_r;
    res_pend_nxt     = res_pend_r;
    res_nxt          = res_r;
    out_valid_nxt    = out_valid_r;
    out_data_nxt     = out_data_r;
    in_ready         = 1'b0;
    ram_wr           = '0;
    ram_rd           = '0;

    // delayed sweep write: copy of the row below, or a space
    if (sweep_wv_r) begin
      ram_wr.en   = 1'b1;
      ram_wr.addr = sweep_wa_r;
      ram_wr.data = (sweep_scroll_r && (sweep_wa_r < ADDR_W'(BOTTOM))) ?
                    ram_rd_data : CHAR_SPACE;
    end

    if (cfg_wr_en) begin
      clr_cfg_nxt = cfg_wr_data;
    end

    // output register drains on transfer
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_SWEEP: begin
        if (sweep_cnt_r < CNT_W'(CELLS)) begin
          sweep_wa_nxt  = sweep_cnt_r[ADDR_W-1:0];
          sweep_wv_nxt  = 1'b1;
          sweep_cnt_nxt = sweep_cnt_r + 1'b1;
          if (sweep_scroll_r && (sweep_cnt_r < CNT_W'(BOTTOM))) begin
            ram_rd.en   = 1'b1;
            ram_rd.addr = ADDR_W'(sweep_cnt_r + CNT_W'(COLUMNS));
          end
        end else begin
          sweep_wv_nxt = 1'b0;
          res_pend_nxt = 1'b0;
          state_nxt    = res_pend_r ? ST_PUSH : ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          res_nxt   = '0;
          state_nxt = ST_PUSH;
          case (in_data.kind)
            KIND_PRINT: begin
              if (in_data.char_code == CODE_CR) begin
                col_v = '0;
                adv   = 1'b1;
              end else if (!in_data.char_code[7] && (in_data.char_code >= CODE_FIRST)) begin
                ram_wr.en   = 1'b1;
                ram_wr.addr = cell_addr(cur_row_r, cur_col_r);
                ram_wr.data = in_data.char_code[CHAR_W-1:0];
                if (cur_col_r == COL_W'(COLUMNS - 1)) begin
                  col_v = '0;
                  adv   = 1'b1;
                end else begin
                  col_v = cur_col_r + 1'b1;
                end
              end
              // move down a row, scrolling at the bottom
              if (adv) begin
                if (cur_row_r == ROW_W'(ROWS - 1)) begin
                  res_nxt.scrolled = 1'b1;
                  sweep_cnt_nxt    = '0;
                  sweep_scroll_nxt = 1'b1;
                  res_pend_nxt     = 1'b1;
                  state_nxt        = ST_SWEEP;
                end else begin
                  row_v = cur_row_r + 1'b1;
                end
              end
            end
            KIND_CLEAR: begin
              start_clear = 1'b1;
            end
            KIND_KEY: begin
              if ((in_data.key_code == KEY_CTRL_L) && clr_cfg_r) begin
                start_clear = 1'b1;
              end else if (in_data.key_code == KEY_DEL) begin
                res_nxt.key_valid = 1'b1;
                res_nxt.key_out   = CHAR_UNDER;
              end else if (in_data.key_code < KEY_LIMIT) begin
                res_nxt.key_valid = 1'b1;
                res_nxt.key_out   = in_data.key_code[6:0];
              end
            end
            KIND_TICK: begin
              if (blink_cnt_r != '0) begin
                blink_cnt_nxt = blink_cnt_r - 1'b1;
              end else begin
                blink_phase_nxt = !blink_phase_r;
                blink_cnt_nxt   = blink_phase_r ? BLINK_W'(BLINK_OFF_TICKS) :
                                                  BLINK_W'(BLINK_ON_TICKS);
              end
            end
            KIND_READ: begin
              if ((in_data.read_row < ROW_W'(ROWS)) &&
                  (in_data.read_col < COL_W'(COLUMNS))) begin
                if (blink_phase_r && (in_data.read_row == cur_row_r) &&
                    (in_data.read_col == cur_col_r)) begin
                  res_nxt.cell_char = CHAR_AT;
                end else begin
                  ram_rd.en   = 1'b1;
                  ram_rd.addr = cell_addr(in_data.read_row, in_data.read_col);
                  state_nxt   = ST_READ;
                end
              end
            end
            default: begin
            end
          endcase

          // blank sweep with the cursor homed
          if (start_clear) begin
            col_v            = '0;
            row_v            = '0;
            sweep_cnt_nxt    = '0;
            sweep_scroll_nxt = 1'b0;
            res_pend_nxt     = 1'b1;
            state_nxt        = ST_SWEEP;
          end

          cur_col_nxt            = col_v;
          cur_row_nxt            = row_v;
          res_nxt.cursor_col     = col_v;
          res_nxt.cursor_row     = row_v;
          res_nxt.cursor_visible = blink_phase_nxt;
        end
      end

      ST_READ: begin
        res_nxt.cell_char = ram_rd_data;
        state_nxt         = ST_PUSH;
      end

      ST_PUSH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    sweep_wa_r <= sweep_wa_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r        <= ST_SWEEP;
      cur_col_r      <= '0;
      cur_row_r      <= '0;
      blink_cnt_r    <= '0;
      blink_phase_r  <= 1'b0;
      clr_cfg_r      <= 1'b0;
      sweep_cnt_r    <= '0;
      sweep_wv_r     <= 1'b0;
      sweep_scroll_r <= 1'b0;
      res_pend_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      cur_col_r      <= cur_col_nxt;
      cur_row_r      <= cur_row_nxt;
      blink_cnt_r    <= blink_cnt_nxt;
      blink_phase_r  <= blink_phase_nxt;
      clr_cfg_r      <= clr_cfg_nxt;
      sweep_cnt_r    <= sweep_cnt_nxt;
      sweep_wv_r     <= sweep_wv_nxt;
      sweep_scroll_r <= sweep_scroll_nxt;
      res_pend_r     <= res_pend_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[tb/text_terminal_screen_writer_checker.sv]
`timescale 1ns / 1ps

module text_terminal_screen_writer_checker #(
  parameter int unsigned BLINK_ON_TICKS  = tts_pkg::BLINK_ON_DEFAULT,
  parameter int unsigned BLINK_OFF_TICKS = tts_pkg::BLINK_OFF_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  tts_pkg::in_item_t         in_data,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  tts_pkg::out_item_t        out_data,
  input  logic                      cfg_wr_en,
  input  logic                      cfg_wr_data,
  output int                        error_count,
  output int                        pending,
  output int                        results_checked,
  output int                        scroll_count,
  output logic [tts_pkg::COL_W-1:0] cursor_col_hint,
  output logic [tts_pkg::ROW_W-1:0] cursor_row_hint
);
  import tts_pkg::*;

  // mirrored screen, cursor, blink and ctrl-L enable
  cell_t            shadow_cells [CELLS];
  logic [COL_W-1:0] cur_x;
  logic [ROW_W-1:0] cur_y;
  int unsigned      blink_left;
  logic             cursor_shown;
  logic             ctrl_l_clears;

  // results still owed by the block, oldest first
  out_item_t        awaited_results [$];
  int               mismatches   = 0;
  int               results_seen = 0;
  int               scrolls      = 0;

  // all cells to space, cursor home
  function automatic void blank_shadow();
    foreach (shadow_cells[i]) shadow_cells[i] = CHAR_SPACE;
    cur_x = '0;
    cur_y = '0;
  endfunction

  // apply one item to the mirror and return the result it should produce
  function automatic out_item_t predict_screen_result(input in_item_t item);
    out_item_t res;
    logic      moved;
    res   = '0;
    moved = 1'b0;
    case (item.kind)
      KIND_PRINT: begin
        if (item.char_code == CODE_CR) begin
          cur_x = '0;
          cur_y = cur_y + 1'b1;
          moved = 1'b1;
        end else if (item.char_code >= CODE_FIRST && !item.char_code[7]) begin
          shadow_cells[cur_y * COLUMNS + cur_x] = item.char_code[6:0];
          cur_x = cur_x + 1'b1;
          // wrap to the next row
          if (cur_x == COLUMNS) begin
            cur_x = '0;
            cur_y = cur_y + 1'b1;
          end
          moved = 1'b1;
        end
        // ran off the bottom: shift rows up, blank the last one
        if (moved && cur_y == ROWS) begin
          cur_y = ROW_W'(ROWS - 1);
          for (int i = 0; i < BOTTOM; i++) shadow_cells[i] = shadow_cells[i + COLUMNS];
          for (int i = BOTTOM; i < CELLS; i++) shadow_cells[i] = CHAR_SPACE;
          res.scrolled = 1'b1;
          scrolls++;
        end
      end
      KIND_CLEAR: blank_shadow();
      KIND_KEY: begin
        if (item.key_code == KEY_CTRL_L && ctrl_l_clears) begin
          blank_shadow();
        end else if (item.key_code == KEY_DEL) begin
          res.key_valid = 1'b1;
          res.key_out   = CHAR_UNDER;
        end else if (item.key_code < KEY_LIMIT) begin
          res.key_valid = 1'b1;
          res.key_out   = item.key_code[6:0];
        end
      end
      KIND_TICK: begin
        // count down, flip phase and reload at zero
        if (blink_left != 0) begin
          blink_left--;
        end else begin
          cursor_shown = !cursor_shown;
          blink_left   = cursor_shown ? BLINK_ON_TICKS : BLINK_OFF_TICKS;
        end
      end
      KIND_READ: begin
        if (item.read_row < ROWS && item.read_col < COLUMNS) begin
          if (cursor_shown && item.read_row == cur_y && item.read_col == cur_x)
            res.cell_char = CHAR_AT;
          else
            res.cell_char = shadow_cells[item.read_row * COLUMNS + item.read_col];
        end
      end
      default: ;
    endcase
    res.cursor_col     = cur_x;
    res.cursor_row     = cur_y;
    res.cursor_visible = cursor_shown;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] result %0d: %s", $time, results_seen, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      blank_shadow();
      blink_left    = 0;
      cursor_shown  = 1'b0;
      ctrl_l_clears = 1'b0;
      awaited_results.delete();
    end else begin
      // result transfer against the oldest expectation
      if (out_valid && out_ready) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          report_mismatch("result transfer with no item outstanding");
        end else begin
          want = awaited_results.pop_front();
          check_field("cell_char", 32'(out_data.cell_char), 32'(want.cell_char));
          check_field("cursor_col", 32'(out_data.cursor_col), 32'(want.cursor_col));
          check_field("cursor_row", 32'(out_data.cursor_row), 32'(want.cursor_row));
          check_field("cursor_visible", 32'(out_data.cursor_visible),
                      32'(want.cursor_visible));
          check_field("scrolled", 32'(out_data.scrolled), 32'(want.scrolled));
          check_field("key_valid", 32'(out_data.key_valid), 32'(want.key_valid));
          check_field("key_out", 32'(out_data.key_out), 32'(want.key_out));
        end
      end

      // input transfer
      if (in_valid && in_ready) awaited_results.push_back(predict_screen_result(in_data));

      // an item at the same edge still sees the old enable
      if (cfg_wr_en) ctrl_l_clears = cfg_wr_data;
    end

    error_count     <= mismatches;
    pending         <= awaited_results.size();
    results_checked <= results_seen;
    scroll_count    <= scrolls;
    cursor_col_hint <= cur_x;
    cursor_row_hint <= cur_y;
  end

endmodule

[tb/text_terminal_screen_writer_tb.sv]
`timescale 1ns / 1ps

module text_terminal_screen_writer_tb;
  import tts_pkg::*;

  localparam int unsigned BLINK_ON_TICKS  = BLINK_ON_DEFAULT;
  localparam int unsigned BLINK_OFF_TICKS = BLINK_OFF_DEFAULT;
  localparam int          RANDOM_ITEMS    = 580;
  localparam int          SETTLE_CYCLES   = 2 * CELLS;
  localparam logic [2:0]  KIND_SPARE_LO   = 3'd5;
  localparam logic [2:0]  KIND_SPARE_HI   = 3'd7;
  localparam logic [7:0]  CODE_TOP        = 8'h7f;

  logic      clk         = 1'b0;
  logic      rst_n       = 1'b0;
  logic      in_valid    = 1'b0;
  in_item_t  in_data     = '0;
  logic      out_ready   = 1'b0;
  logic      cfg_wr_en   = 1'b0;
  logic      cfg_wr_data = 1'b0;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_data;

  int               error_count;
  int               pending;
  int               results_checked;
  int               scroll_count;
  logic [COL_W-1:0] cursor_col_hint;
  logic [ROW_W-1:0] cursor_row_hint;

  int send_idle_pct = 36;
  int recv_idle_pct = 76;
  int items_sent    = 0;
  int spare_sent    = 0;
  int sent_per_kind [8];

  text_terminal_screen_writer #(
    .BLINK_ON_TICKS (BLINK_ON_TICKS),
    .BLINK_OFF_TICKS(BLINK_OFF_TICKS)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  text_terminal_screen_writer_checker #(
    .BLINK_ON_TICKS (BLINK_ON_TICKS),
    .BLINK_OFF_TICKS(BLINK_OFF_TICKS)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .error_count    (error_count),
    .pending        (pending),
    .results_checked(results_checked),
    .scroll_count   (scroll_count),
    .cursor_col_hint(cursor_col_hint),
    .cursor_row_hint(cursor_row_hint)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // the given kind, random filler in every other field
  function automatic in_item_t random_item(input logic [2:0] kind);
    in_item_t item;
    item.kind      = kind;
    item.char_code = 8'($urandom);
    item.key_code  = 21'($urandom);
    item.read_row  = ROW_W'($urandom);
    item.read_col  = COL_W'($urandom);
    return item;
  endfunction

  // one input transfer, with a random idle gap ahead of it
  task automatic send_item(input in_item_t item);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (item.kind > KIND_READ) spare_sent++;
    else sent_per_kind[item.kind]++;
  endtask

  task automatic send_print(input logic [7:0] code);
    in_item_t item;
    item = random_item(KIND_PRINT);
    item.char_code = code;
    send_item(item);
  endtask

  task automatic send_key(input logic [20:0] code);
    in_item_t item;
    item = random_item(KIND_KEY);
    item.key_code = code;
    send_item(item);
  endtask

  task automatic send_read(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
    in_item_t item;
    item = random_item(KIND_READ);
    item.read_row = row;
    item.read_col = col;
    send_item(item);
  endtask

  task automatic send_other(input logic [2:0] kind);
    send_item(random_item(kind));
  endtask

  // stop sending and wait for every owed result
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_ctrl_l_clear(input logic value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // random text sessions: lines of text and returns, with ticks, reads, keys, clears and unused kinds mixed in
  task automatic run_phase(input int target);
    int start;
    int len;
    int pick;
    int sub;
    start = items_sent;
    while (items_sent - start < target) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        // a line of text, mostly short, sometimes long enough to wrap
        sub = $urandom_range(9);
        if (sub < 7) len = $urandom_range(4);
        else if (sub < 9) len = $urandom_range(39, 5);
        else len = $urandom_range(85, 40);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(19) == 0) send_print(8'($urandom));
          else send_print(8'($urandom_range(CODE_TOP, CODE_FIRST)));
        end
        if ($urandom_range(9) < 8) send_print(CODE_CR);
      end else if (pick < 65) begin
        repeat ($urandom_range(8, 1)) send_print(CODE_CR);
      end else if (pick < 77) begin
        repeat ($urandom_range(12, 1)) send_other(KIND_TICK);
      end else if (pick < 89) begin
        repeat ($urandom_range(4, 1)) begin
          sub = $urandom_range(9);
          if (sub < 5) send_read(cursor_row_hint, cursor_col_hint);
          else if (sub < 9)
            send_read(ROW_W'($urandom_range(ROWS - 1)), COL_W'($urandom_range(COLUMNS - 1)));
          else send_read(ROW_W'($urandom), COL_W'($urandom));
        end
      end else if (pick < 97) begin
        repeat ($urandom_range(3, 1)) begin
          sub = $urandom_range(9);
          if (sub < 6) send_key(21'($urandom_range(127)));
          else if (sub < 7) send_key(KEY_DEL);
          else if (sub < 8) send_key(KEY_CTRL_L);
          else send_key(21'($urandom));
        end
      end else if (pick < 98) begin
        send_other(KIND_CLEAR);
      end else begin
        send_other(3'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO)));
      end
    end
  endtask

  // stimulus and verdict
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: print range edges, returns, reads in and out of range
    send_read('0, '0);
    send_print("A");
    send_print(CODE_TOP);
    send_print(CODE_FIRST);
    send_print(CODE_FIRST - 8'd1);
    send_print({1'b1, CODE_CR[6:0]});
    send_print(8'hff);
    send_print(8'h00);
    send_print(CODE_CR);
    send_read('0, '0);
    send_read('0, COL_W'(1));
    send_read(ROW_W'(ROWS - 1), COL_W'(COLUMNS - 1));
    send_read(ROW_W'(ROWS), '0);
    send_read('0, COL_W'(COLUMNS));
    send_read('1, '1);
    // keys: DEL, null, first dropped code, widest code, ctrl-L forwarded
    send_key(KEY_DEL);
    send_key('0);
    send_key(KEY_LIMIT);
    send_key('1);
    send_key(KEY_CTRL_L);
    // first tick shows the cursor over the cell at row 1, column 0
    send_other(KIND_TICK);
    send_read(ROW_W'(1), '0);
    send_other(KIND_SPARE_LO);
    send_other(KIND_SPARE_HI);
    send_other(KIND_CLEAR);
    wait_drained();

    // ctrl-L clears during this phase
    set_ctrl_l_clear(1'b1);
    send_key(KEY_CTRL_L);
    run_phase(RANDOM_ITEMS / 3);
    wait_drained();

    send_idle_pct = 76;
    recv_idle_pct = 36;
    set_ctrl_l_clear(1'b0);
    run_phase(RANDOM_ITEMS / 3);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_ctrl_l_clear(1'b1);
    run_phase(RANDOM_ITEMS / 3);
    wait_drained();

    // catch any stray result after the last one
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d items: %0d print, %0d clear, %0d key, %0d tick, %0d read, %0d unused",
             items_sent, sent_per_kind[KIND_PRINT], sent_per_kind[KIND_CLEAR],
             sent_per_kind[KIND_KEY], sent_per_kind[KIND_TICK], sent_per_kind[KIND_READ],
             spare_sent);
    $display("%0d results compared, %0d scrolls, ctrl-L clear enable set and cleared",
             results_checked, scroll_count);
    if (error_count == 0 && pending == 0) begin
      $display("** text_terminal_screen_writer: PASSED **");
    end else begin
      $display("** text_terminal_screen_writer: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("** text_terminal_screen_writer: FAILED **");
    $finish;
  end

endmodule

[sim.f]
hdl/tts_pkg.sv
hdl/tts_cell_ram.sv
hdl/text_terminal_screen_writer.sv
tb/text_terminal_screen_writer_checker.sv
tb/text_terminal_screen_writer_tb.sv
